// ----- hw/rtl/aes_round_transform_assert.svh -----
// Assertion macros for the AES round transform block.
`ifndef AES_ROUND_TRANSFORM_ASSERT_SVH
`define AES_ROUND_TRANSFORM_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define ART_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define ART_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/art_pkg.sv -----
// Package: GF(2^8) helpers, S-box functions and shared types.
package art_pkg;

  typedef logic [7:0] byte_t;
  typedef byte_t [15:0] state_t;

  typedef struct packed {
    logic inverse;
    logic skip;
  } ctrl_t;

  function automatic byte_t xtime(byte_t a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t p;
    byte_t x;
    p = '0;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ x;
      x = xtime(x);
    end
    gf_mul = p;
  endfunction

  function automatic byte_t gf_inv(byte_t x);
    byte_t sq;
    byte_t acc;
    sq = gf_mul(x, x);
    acc = sq;
    for (int i = 0; i < 6; i++) begin
      sq = gf_mul(sq, sq);
      acc = gf_mul(acc, sq);
    end
    gf_inv = acc;
  endfunction

  function automatic byte_t rotl(byte_t b, int n);
    rotl = byte_t'((b << n) | (b >> (8 - n)));
  endfunction

  function automatic byte_t sbox(byte_t x);
    byte_t v;
    v = gf_inv(x);
    sbox = v ^ rotl(v, 1) ^ rotl(v, 2) ^ rotl(v, 3) ^ rotl(v, 4) ^ 8'h63;
  endfunction

  function automatic byte_t inv_sbox(byte_t y);
    inv_sbox = gf_inv(rotl(y, 1) ^ rotl(y, 3) ^ rotl(y, 6) ^ 8'h05);
  endfunction

  // Constant S-box tables, built at elaboration.
  function automatic logic [255:0][7:0] fwd_table();
    logic [255:0][7:0] t;
    for (int i = 0; i < 256; i++) t[i] = sbox(byte_t'(i));
    fwd_table = t;
  endfunction

  function automatic logic [255:0][7:0] inv_table();
    logic [255:0][7:0] t;
    for (int i = 0; i < 256; i++) t[i] = inv_sbox(byte_t'(i));
    inv_table = t;
  endfunction

  localparam logic [255:0][7:0] SBOX_FWD = fwd_table();
  localparam logic [255:0][7:0] SBOX_INV = inv_table();

  // Byte index n: row n%4, column n/4. Source of out(r,c) in ShiftRows.
  function automatic int shift_src(int n, logic inverse);
    int r;
    int c;
    r = n % 4;
    c = n / 4;
    shift_src = 4 * (inverse ? ((c + 4 - r) % 4) : ((c + r) % 4)) + r;
  endfunction

endpackage

// ----- hw/rtl/aes_round_transform.sv -----
// Top level: two-stage AES round transform without AddRoundKey.
// Slave channel s_axis: tdata fields from bit 0 are state_high, state_low, mode, skip_mix:
// state_high [63:0], state_low [127:64], mode [128], skip_mix [129], zero filled to 136.
// Master channel m_axis: tdata = state_high [63:0], state_low [127:64].
// Stage 1 holds the input after the forward S-boxes (inverse: after InvMixColumns);
// stage 2 holds the result after ShiftRows and the other half of the round.
// A block is registered in stage 1, then in stage 2, where its result turns valid.
// Throughput: one block per cycle while m_axis does not stall; sixteen S-box lanes
// and four column lanes run in parallel each stage; the byte permutation merges them.
// Reset clears both stage valid bits; no payload is cleared.
// A stall on m_axis holds the pipeline; s_axis_tready follows stage-1 space,
// so a new block is still taken while a result waits if stage 1 is empty or will drain.
module aes_round_transform import art_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [135:0] s_axis_tdata_i,  // state_high, state_low, mode, skip_mix
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o   // result_high, result_low
);
  state_t in_s, s1_d, s1_q, sh, s2_d, s2_q, sb1, sb2, mx1, mx2;
  ctrl_t  c_in, c1_q;
  logic   v1_q, v2_q, adv2, adv1;

  // byte n of state sits at bits of high/low per FIPS order
  always_comb begin
    for (int n = 0; n < 8; n++) begin
      in_s[n]     = s_axis_tdata_i[56 - 8*n +: 8];
      in_s[n + 8] = s_axis_tdata_i[64 + 56 - 8*n +: 8];
    end
  end
  assign c_in = '{inverse: s_axis_tdata_i[128], skip: s_axis_tdata_i[129]};

  for (genvar g = 0; g < 16; g++) begin : g_sub
    art_sub_lane u_s1 (.in_i(in_s[g]), .inverse_i(1'b0), .out_o(sb1[g]));
    art_sub_lane u_s2 (.in_i(sh[g]), .inverse_i(1'b1), .out_o(sb2[g]));
  end
  for (genvar g = 0; g < 4; g++) begin : g_mix
    art_mix_lane u_m1 (.col_i(in_s[4*g +: 4]), .inverse_i(1'b1), .skip_i(c_in.skip),
                       .col_o(mx1[4*g +: 4]));
    art_mix_lane u_m2 (.col_i(sh[4*g +: 4]), .inverse_i(1'b0), .skip_i(c1_q.skip),
                       .col_o(mx2[4*g +: 4]));
  end

  assign s1_d = c_in.inverse ? mx1 : sb1;
  always_comb begin
    for (int n = 0; n < 16; n++) sh[n] = s1_q[4'(shift_src(n, c1_q.inverse))];
  end
  assign s2_d = c1_q.inverse ? sb2 : mx2;

  assign adv2 = v1_q && (!v2_q || m_axis_tready_i);
  assign adv1 = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !v1_q || adv2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= 1'b1;
      else if (adv2) v1_q <= 1'b0;
      if (adv2) v2_q <= 1'b1;
      else if (m_axis_tready_i) v2_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s1_q <= s1_d;
      c1_q <= c_in;
    end
    if (adv2) s2_q <= s2_d;
  end

  assign m_axis_tvalid_o = v2_q;
  always_comb begin
    for (int n = 0; n < 8; n++) begin
      m_axis_tdata_o[56 - 8*n +: 8]      = s2_q[n];
      m_axis_tdata_o[64 + 56 - 8*n +: 8] = s2_q[n + 8];
    end
  end

`include "aes_round_transform_assert.svh"
  `ART_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o, "result dropped under stall")
  `ART_ASSERT_IMP(a_ready, clk_i, rst_ni, !v1_q, s_axis_tready_o,
                  "empty stage 1 not ready")
  `ART_ASSERT_NEXT(a_fill, clk_i, rst_ni, adv1, v1_q, "accepted block lost")
endmodule

// ----- hw/rtl/art_sub_lane.sv -----
// One byte lane: forward or inverse S-box lookup.
module art_sub_lane import art_pkg::*; (
  input  byte_t in_i,
  input  logic  inverse_i,
  output byte_t out_o
);
  assign out_o = inverse_i ? SBOX_INV[in_i] : SBOX_FWD[in_i];
endmodule

// ----- hw/rtl/art_mix_lane.sv -----
// One column lane: forward or inverse MixColumns with bypass.
module art_mix_lane import art_pkg::*; (
  input  byte_t [3:0] col_i,
  input  logic        inverse_i,
  input  logic        skip_i,
  output byte_t [3:0] col_o
);
  byte_t [3:0] k;
  always_comb begin
    k = inverse_i ? {8'd9, 8'd13, 8'd11, 8'd14} : {8'd1, 8'd1, 8'd3, 8'd2};
    for (int r = 0; r < 4; r++) begin
      col_o[r] = '0;
      for (int j = 0; j < 4; j++) col_o[r] = col_o[r] ^ gf_mul(k[(j + 4 - r) % 4], col_i[j]);
      if (skip_i) col_o[r] = col_i[r];
    end
  end
endmodule
